// ----- src/gauge_stepper_microstep_sequencer_top_defines.svh -----
// Assertion macros for the gauge stepper microstep sequencer.
// Used by gauge_stepper_microstep_sequencer_top; needs signals clk and rst_n in scope.
`ifndef GAUGE_STEPPER_MICROSTEP_SEQUENCER_TOP_DEFINES_SVH
`define GAUGE_STEPPER_MICROSTEP_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define GSMS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gsms assertion failed");
`define GSMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gsms assertion failed");
`else
`define GSMS_ASSERT(lbl, prop)
`define GSMS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- src/gsms_pkg.sv -----
// Shared constants for the gauge stepper microstep sequencer.
// No dependencies; used by gauge_stepper_microstep_sequencer_top.
`default_nettype none

package gsms_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_ZERO_OFFSET  = 2'd0;
    localparam cfg_index_t CFG_MAX_POSITION = 2'd1;
    localparam cfg_index_t CFG_EXTRA_STEPS  = 2'd2;

    // Step size in start-up mode.
    localparam int unsigned JUMP_STEPS = 4;

    // Field widths.
    localparam int unsigned POS_W    = 16;
    localparam int unsigned PERIOD_W = 15;
    localparam int unsigned EXTRA_W  = 8;
    localparam int unsigned INDEX_W  = 7;
    localparam int unsigned COUNT_W  = 16;

    typedef logic signed [POS_W-1:0] pos_t;

endpackage

`default_nettype wire

// ----- src/gauge_stepper_microstep_sequencer_top.sv -----
// Top level of the gauge stepper microstep sequencer: input register, step logic, result register.
// Depends on gsms_pkg and gauge_stepper_microstep_sequencer_top_defines.svh.
`default_nettype none
`include "gauge_stepper_microstep_sequencer_top_defines.svh"

// Usage
// Each input word is one timer tick for one gauge motor: target position, step period,
// move enable and start-up flag. Each tick yields exactly one result word carrying the
// microstep index, a stepped flag, the needle position, the step count and an on-target flag.
// Both channels use valid and stall; a word moves at a clock edge where valid is high
// and stall is low.
// A tick lands in the input register; as it moves on, the step logic updates the motor
// state and loads the result register.
// Throughput is one tick per cycle while the receiver does not stall. The motor state is
// only a handful of registers and the compare, decrement and add between them are
// combinational, so consecutive ticks follow each other without a gap.
// When the receiver stalls, the result register holds its word and the input register
// still takes one more tick; the input side stalls only while both registers are full.
// Configuration is written through cfg_we, cfg_index and cfg_data while the block is idle.
// Reset (rst_n low, asynchronous) empties both registers, puts the needle at zero, the
// microstep index at minus one, and clears the countdown and the step counter. The
// configuration returns to zero offset 0, maximum 32767 and no extra steps.
module gauge_stepper_microstep_sequencer_top #(
    parameter int unsigned TABLE_SIZE = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [gsms_pkg::POS_W-1:0]    target_position,
    input  wire logic        [gsms_pkg::PERIOD_W-1:0] step_period,
    input  wire logic                                 move_enable,
    input  wire logic                                 startup_mode,

    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [gsms_pkg::INDEX_W-1:0]       microstep_index,
    output logic                                      stepped,
    output logic signed [gsms_pkg::POS_W-1:0]         needle_position,
    output logic        [gsms_pkg::COUNT_W-1:0]       steps_taken,
    output logic                                      at_target,

    input  wire logic                                 cfg_we,
    input  wire gsms_pkg::cfg_index_t                 cfg_index,
    input  wire logic        [gsms_pkg::POS_W-1:0]    cfg_data
);

    // The stored index spans -1 to TABLE_SIZE-1; the sum needs room for a jump past the top.
    localparam int unsigned PH_W = $clog2(TABLE_SIZE) + 1;
    localparam int unsigned PS_W = PH_W + 1;
    localparam int unsigned SUM_W = gsms_pkg::POS_W + 2;
    localparam int unsigned LIM_W = gsms_pkg::POS_W + 1;

    localparam logic signed [PS_W-1:0] TS_S      = PS_W'(TABLE_SIZE);
    localparam logic signed [PS_W-1:0] WRAP_ONE  = PS_W'(TABLE_SIZE - 1);
    localparam logic signed [PS_W-1:0] WRAP_JUMP = PS_W'(TABLE_SIZE - gsms_pkg::JUMP_STEPS + 1);
    localparam logic signed [LIM_W-1:0] POS_MAX  = LIM_W'(32767);

    // Configuration registers.
    gsms_pkg::pos_t                   zero_offset_reg;
    gsms_pkg::pos_t                   max_position_reg;
    logic [gsms_pkg::EXTRA_W-1:0]     extra_steps_reg;

    // Input register.
    logic                             in_full_reg;
    gsms_pkg::pos_t                   tgt_reg;
    logic [gsms_pkg::PERIOD_W-1:0]    period_reg;
    logic                             enable_reg;
    logic                             jump_reg;

    // Motor state.
    gsms_pkg::pos_t                   pos_reg;
    gsms_pkg::pos_t                   pos_next;
    logic signed [PH_W-1:0]           phase_reg;
    logic signed [PH_W-1:0]           phase_next;
    logic [gsms_pkg::PERIOD_W-1:0]    cnt_reg;
    logic [gsms_pkg::PERIOD_W-1:0]    cnt_next;
    logic [gsms_pkg::COUNT_W-1:0]     step_count_reg;
    logic [gsms_pkg::COUNT_W-1:0]     step_count_next;

    // Result register.
    logic                             out_valid_reg;
    logic signed [gsms_pkg::INDEX_W-1:0] index_reg;
    logic                             stepped_reg;
    gsms_pkg::pos_t                   needle_reg;
    logic [gsms_pkg::COUNT_W-1:0]     steps_reg;
    logic                             at_target_reg;

    logic                             load_out;
    logic                             in_accept;
    logic                             moving;
    logic                             expire;
    logic signed [3:0]                amount;
    logic signed [gsms_pkg::EXTRA_W:0] extra_s;
    logic signed [LIM_W-1:0]          lim_sum;
    gsms_pkg::pos_t                   limit;
    logic signed [SUM_W-1:0]          pos_up;
    logic signed [SUM_W-1:0]          pos_down;
    logic signed [PS_W-1:0]           ph_up;
    logic signed [PS_W-1:0]           ph_down;

    // Handshake: the result register takes a word when empty or when its word leaves.
    assign load_out  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !load_out;
    assign in_accept = in_valid && !in_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg  <= '0;
            max_position_reg <= 16'sh7FFF;
            extra_steps_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gsms_pkg::CFG_ZERO_OFFSET:  zero_offset_reg  <= cfg_data;
                gsms_pkg::CFG_MAX_POSITION: max_position_reg <= cfg_data;
                gsms_pkg::CFG_EXTRA_STEPS:  extra_steps_reg  <= cfg_data[gsms_pkg::EXTRA_W-1:0];
                default: ;
            endcase
        end
    end

    // Step logic.
    always_comb
    begin
        moving = enable_reg && (tgt_reg != pos_reg);
        // The countdown is decremented first; it expires when that leaves it at zero or below.
        expire = moving && (cnt_reg <= gsms_pkg::PERIOD_W'(1));
        amount = jump_reg ? 4'sd4 : 4'sd1;

        extra_s = {1'b0, extra_steps_reg};
        lim_sum = LIM_W'(max_position_reg) + LIM_W'(extra_s);
        limit   = (lim_sum > POS_MAX) ? 16'sh7FFF : lim_sum[gsms_pkg::POS_W-1:0];

        pos_up   = SUM_W'(pos_reg) + SUM_W'(amount);
        pos_down = SUM_W'(pos_reg) - SUM_W'(amount);
        ph_up    = PS_W'(phase_reg) + PS_W'(amount);
        ph_down  = PS_W'(phase_reg) - PS_W'(amount);

        pos_next        = pos_reg;
        phase_next      = phase_reg;
        step_count_next = step_count_reg;
        cnt_next        = cnt_reg;

        if (moving)
        begin
            cnt_next = cnt_reg - gsms_pkg::PERIOD_W'(1);
        end

        if (expire)
        begin
            cnt_next        = period_reg;
            step_count_next = step_count_reg + gsms_pkg::COUNT_W'(1);
            if (tgt_reg > pos_reg)
            begin
                // Clockwise: wrap the index to zero, clamp at the top limit.
                phase_next = (ph_up >= TS_S) ? '0 : ph_up[PH_W-1:0];
                pos_next   = (pos_up > SUM_W'(limit)) ? limit : pos_up[gsms_pkg::POS_W-1:0];
            end
            else
            begin
                // Counter-clockwise: a negative index wraps near the top of the table.
                if (ph_down < PS_W'(0))
                    phase_next = jump_reg ? WRAP_JUMP[PH_W-1:0] : WRAP_ONE[PH_W-1:0];
                else
                    phase_next = ph_down[PH_W-1:0];
                pos_next = (pos_down < SUM_W'(zero_offset_reg)) ? zero_offset_reg
                                                                : pos_down[gsms_pkg::POS_W-1:0];
            end
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_full_reg <= 1'b1;
        end
        else if (load_out)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            tgt_reg    <= target_position;
            period_reg <= step_period;
            enable_reg <= move_enable;
            jump_reg   <= startup_mode;
        end
    end

    // Motor state advances once per tick, as the tick moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            phase_reg      <= '1;
            cnt_reg        <= '0;
            step_count_reg <= '0;
        end
        else if (load_out)
        begin
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            step_count_reg <= step_count_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            index_reg     <= gsms_pkg::INDEX_W'(phase_next);
            stepped_reg   <= expire;
            needle_reg    <= pos_next;
            steps_reg     <= step_count_next;
            at_target_reg <= (pos_next == tgt_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign microstep_index = index_reg;
    assign stepped         = stepped_reg;
    assign needle_position = needle_reg;
    assign steps_taken     = steps_reg;
    assign at_target       = at_target_reg;

    // The input side stalls only while a tick is waiting in the input register.
    `GSMS_ASSERT(a_stall_needs_full, !in_stall || in_full_reg)
    // A step reloads the countdown from the tick's period.
    `GSMS_ASSERT_NEXT(a_reload_on_step, load_out && expire, cnt_reg == $past(period_reg))
    // The step counter grows by exactly the stepped flag of each loaded word.
    `GSMS_ASSERT_NEXT(a_count_tracks_step, load_out,
        step_count_reg == $past(step_count_reg) + gsms_pkg::COUNT_W'($past(expire)))
    // A word that has no step leaves the needle where it was.
    `GSMS_ASSERT_NEXT(a_hold_without_step, load_out && !expire, pos_reg == $past(pos_reg))

endmodule

`default_nettype wire
